// ===== rtl/csem_pkg.sv =====
// shared types and constants for the counting semaphore with wait queue
package csem_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TID_W       = 8;
  localparam int CNT_W       = 16;
  localparam int INIT_W      = 15;
  localparam int USED_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STAT_W      = 3;

  // count saturation limit and value after reset
  localparam logic signed [CNT_W-1:0] COUNT_MAX  = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] COUNT_INIT = CNT_W'(1);

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_WOKE     = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  // queue control from the counter logic
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } q_ctrl_t;

  // queue occupancy flags back to the counter logic
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/counting_semaphore_with_wait_queue.sv =====
// counting semaphore with a fifo wait queue, one operation per transfer
// the count and the queue update with each input transfer, whose result is registered
// throughput: one operation per cycle while the output is empty or being taken
// reset: count loads 1 and the wait queue empties at once; a cfg write does the same
// with the written value
// no clearing pass; the input is ready right after reset
module counting_semaphore_with_wait_queue import csem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // thread_id[7:0]
  input  logic [0:0]        s_axis_tuser,   // cmd[0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // woken_thread[7:0], count_after[23:8]
  output logic [2:0]        m_axis_tuser,   // status[2:0]
  input  logic              cfg_we_i,
  input  logic [INIT_W-1:0] cfg_wdata_i
);

  logic                    in_xfer;
  cmd_e                    cmd;
  logic signed [CNT_W-1:0] count_q, count_d;
  logic signed [CNT_W-1:0] cnt_dec, cnt_inc;
  status_e                 res_stat;
  logic [TID_W-1:0]        res_woken;
  logic                    want_push, want_pop;
  q_ctrl_t                 q_ctrl;
  q_stat_t                 q_stat;
  logic [TID_W-1:0]        q_head;
  logic                    out_valid_q;
  status_e                 stat_q;
  logic [TID_W-1:0]        woken_q;
  logic signed [CNT_W-1:0] cnt_out_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser[0]);

  // operation decode and next count
  always_comb begin
    cnt_dec   = count_q - CNT_W'(1);
    cnt_inc   = (count_q < COUNT_MAX) ? count_q + CNT_W'(1) : count_q;
    count_d   = count_q;
    res_stat  = ST_GRANTED;
    res_woken = '0;
    want_push = 1'b0;
    want_pop  = 1'b0;
    unique case (cmd)
      CMD_ACQUIRE: begin
        if (cnt_dec >= 0) begin
          count_d  = cnt_dec;
          res_stat = ST_GRANTED;
        end else if (q_stat.full) begin
          res_stat = ST_REFUSED;
        end else begin
          count_d   = cnt_dec;
          want_push = 1'b1;
          res_stat  = ST_BLOCKED;
        end
      end
      CMD_RELEASE: begin
        count_d = cnt_inc;
        if (cnt_inc <= 0 && !q_stat.empty) begin
          want_pop  = 1'b1;
          res_stat  = ST_WOKE;
          res_woken = q_head;
        end else begin
          res_stat = ST_RELEASED;
        end
      end
      default: begin
        res_stat = ST_RELEASED;
      end
    endcase
  end

  // queue pushes and pops only on an accepted transfer; a cfg write clears it
  assign q_ctrl.clr  = cfg_we_i;
  assign q_ctrl.push = in_xfer && want_push && !cfg_we_i;
  assign q_ctrl.pop  = in_xfer && want_pop && !cfg_we_i;

  csem_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(q_ctrl),
    .tid_i (s_axis_tdata[TID_W-1:0]),
    .stat_o(q_stat),
    .head_o(q_head)
  );

  // semaphore count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_INIT;
    end else if (cfg_we_i) begin
      count_q <= $signed({1'b0, cfg_wdata_i});
    end else if (in_xfer) begin
      count_q <= count_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stat_q    <= res_stat;
      woken_q   <= res_woken;
      cnt_out_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = stat_q;
  assign m_axis_tdata  = {cnt_out_q, woken_q};

  // a wake-up only happens with the count at zero or below
  a_woke_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_q == ST_WOKE) |-> (cnt_out_q <= 0))
    else $error("waiter woken with positive count");

  // count never drops below what the queue can hold
  a_count_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= -$signed(CNT_W'(QUEUE_DEPTH)))
    else $error("semaphore count below queue depth");

  // a release with no waiters never reports a wake-up
  a_no_phantom_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cmd == CMD_RELEASE && q_stat.empty) |=> (stat_q != ST_WOKE))
    else $error("wake-up reported with empty queue");

endmodule

// ===== rtl/csem_cell.sv =====
// one slot of the wait queue shift chain
module csem_cell import csem_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,   // take the new id
  input  logic             shift_i,  // take the neighbor's id
  input  logic [TID_W-1:0] id_i,
  input  logic [TID_W-1:0] nxt_i,
  output logic [TID_W-1:0] id_o
);

  logic [TID_W-1:0] id_q;

  // slot storage, payload only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      id_q <= id_i;
    end else if (shift_i) begin
      id_q <= nxt_i;
    end
  end

  assign id_o = id_q;

endmodule

// ===== rtl/csem_queue.sv =====
// fifo of waiting thread ids built as a chain of shifting cells
module csem_queue import csem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctrl_t          ctrl_i,
  input  logic [TID_W-1:0] tid_i,
  output q_stat_t          stat_o,
  output logic [TID_W-1:0] head_o
);

  logic [USED_W-1:0] used_q;
  logic [TID_W-1:0]  id_w [QUEUE_DEPTH];
  logic              shift;

  assign shift = ctrl_i.pop && !ctrl_i.clr;

  // cell 0 is the oldest waiter; a pop moves every cell one step toward it
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TID_W-1:0] nxt;
    logic             load;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = id_w[i+1];
    end

    // a push lands in the first free cell
    assign load = ctrl_i.push && !ctrl_i.clr && (used_q == USED_W'(i));

    csem_cell u_cell (
      .clk_i  (clk_i),
      .load_i (load),
      .shift_i(shift),
      .id_i   (tid_i),
      .nxt_i  (nxt),
      .id_o   (id_w[i])
    );
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ctrl_i.clr) begin
      used_q <= '0;
    end else if (ctrl_i.push) begin
      used_q <= used_q + USED_W'(1);
    end else if (ctrl_i.pop) begin
      used_q <= used_q - USED_W'(1);
    end
  end

  assign stat_o.full  = (used_q >= USED_W'(QUEUE_DEPTH));
  assign stat_o.empty = (used_q == '0);
  assign head_o       = id_w[0];

  // fill count stays within the chain
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(QUEUE_DEPTH))
    else $error("wait queue fill count beyond depth");

  // no push into a full chain
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !stat_o.full)
    else $error("push into full wait queue");

  // no pop from an empty chain, and never push and pop together
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (!stat_o.empty && !ctrl_i.push))
    else $error("bad pop from wait queue");

endmodule
